### rtl/hsc_pkg.sv
package hsc_pkg;

   typedef enum logic [0:0] {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CORRECTED = 2'd1,
      STATUS_DOUBLE    = 2'd2
   } status_type;

   localparam int FIRST_DATA_POS = 3;

   // smallest r >= 2 with 2^r - r - 1 >= data_bits, capped at 7
   function automatic int ham_bits(input int data_bits);
      int r;
      r = 2;
      while (r < 7 && ((1 << r) - r - 1) < data_bits) begin
         r++;
      end
      return r;
   endfunction

   function automatic int code_len(input int data_bits);
      int n;
      n = data_bits + ham_bits(data_bits) + 1;
      return (n > 64) ? 64 : n;
   endfunction

   function automatic bit is_pow2(input int p);
      return (p & (p - 1)) == 0;
   endfunction

endpackage

### rtl/hsc_syndrome.sv
module hsc_syndrome #(
   parameter int DATA_BITS = 32
) (
   input  logic [hsc_pkg::code_len(DATA_BITS)-1:0] word,
   output logic [hsc_pkg::ham_bits(DATA_BITS)-1:0] syndrome,
   output logic                                    parity
);
   import hsc_pkg::*;

   localparam int R        = ham_bits(DATA_BITS);
   localparam int CODE_LEN = code_len(DATA_BITS);

   // syndrome bit b: XOR of all positions whose index has bit b set
   always_comb begin
      syndrome = '0;
      for (int b = 0; b < R; b++) begin
         for (int p = 1; p < CODE_LEN; p++) begin
            if (((p >> b) & 1) != 0) begin
               syndrome[b] = syndrome[b] ^ word[p];
            end
         end
      end
   end

   assign parity = ^word;

endmodule

### rtl/hamming_secded_codec.sv
// channel | dir | tdata (low bit up)                  | tuser
// req     | in  | data_word, codeword, zero pad       | op
// rsp     | out | codeword_out, data_out, zero pad    | status
//
// Three register stages: input capture, syndrome/parity XOR tree,
// correct/extract plus output register. One transaction is taken every
// cycle while rsp is not stalled.
// Synchronous active-high reset clears the stage valid bits only.
// A stalled rsp backs up stage by stage; each stage advances when the
// one after it is empty or moving, so nothing is dropped or repeated.
module hamming_secded_codec #(
   parameter int DATA_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // data_word, codeword
   input  logic [((DATA_BITS + hsc_pkg::code_len(DATA_BITS) + 7) / 8) * 8 - 1:0] req_tdata,
   // op
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // codeword_out, data_out
   output logic [((DATA_BITS + hsc_pkg::code_len(DATA_BITS) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);
   import hsc_pkg::*;

   localparam int R        = ham_bits(DATA_BITS);
   localparam int CODE_LEN = code_len(DATA_BITS);
   localparam int BUS_W    = ((DATA_BITS + CODE_LEN + 7) / 8) * 8;

   // stage 1: captured request
   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic [DATA_BITS-1:0] s1_data_ff;
   logic [CODE_LEN-1:0] s1_code_ff;

   // stage 2: word under test with its syndrome and parity
   logic                s2_valid_ff;
   op_type              s2_op_ff;
   logic [CODE_LEN-1:0] s2_word_ff, s2_word_in;
   logic [R-1:0]        s2_syn_ff, s2_syn_in;
   logic                s2_par_ff, s2_par_in;

   // stage 3: output register
   logic                 s3_valid_ff;
   logic [CODE_LEN-1:0]  s3_code_ff, s3_code_in;
   logic [DATA_BITS-1:0] s3_data_ff, s3_data_in;
   status_type           s3_status_ff, s3_status_in;

   logic ready1, ready2, ready3;

   assign ready3     = !s3_valid_ff || rsp_tready;
   assign ready2     = !s2_valid_ff || ready3;
   assign ready1     = !s1_valid_ff || ready2;
   assign req_tready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready1) begin
         s1_valid_ff <= req_tvalid;
      end
      if (ready1) begin
         s1_op_ff   <= op_type'(req_tuser[0]);
         s1_data_ff <= req_tdata[DATA_BITS-1:0];
         s1_code_ff <= req_tdata[DATA_BITS +: CODE_LEN];
      end
   end

   // data bits into non-power-of-two positions from position 3 upward
   logic [CODE_LEN-1:0] placed;
   always_comb begin
      int k;
      k = 0;
      placed = '0;
      for (int p = FIRST_DATA_POS; p < CODE_LEN; p++) begin
         if (!is_pow2(p) && k < DATA_BITS) begin
            placed[p] = s1_data_ff[k];
            k++;
         end
      end
   end

   assign s2_word_in = (s1_op_ff == OP_DECODE) ? s1_code_ff : placed;

   hsc_syndrome #(
      .DATA_BITS(DATA_BITS)
   ) u_syndrome (
      .word     (s2_word_in),
      .syndrome (s2_syn_in),
      .parity   (s2_par_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (ready2) begin
         s2_op_ff   <= s1_op_ff;
         s2_word_ff <= s2_word_in;
         s2_syn_ff  <= s2_syn_in;
         s2_par_ff  <= s2_par_in;
      end
   end

   // stage 3 logic
   logic [CODE_LEN-1:0] encoded, fixed;
   logic                syn_in_range;

   always_comb begin
      encoded = s2_word_ff;
      for (int i = 0; i < R; i++) begin
         encoded[1 << i] = s2_syn_ff[i];
      end
      encoded[0] = s2_par_ff ^ (^s2_syn_ff);
   end

   assign syn_in_range = {1'b0, s2_syn_ff} < (R + 1)'(CODE_LEN);

   always_comb begin
      fixed        = s2_word_ff;
      s3_status_in = STATUS_OK;
      if (s2_syn_ff == '0) begin
         s3_status_in = s2_par_ff ? STATUS_CORRECTED : STATUS_OK;
      end else if (!s2_par_ff || !syn_in_range) begin
         s3_status_in = STATUS_DOUBLE;
      end else begin
         fixed        = s2_word_ff ^ (CODE_LEN'(1) << s2_syn_ff);
         s3_status_in = STATUS_CORRECTED;
      end
      if (s2_op_ff == OP_ENCODE) begin
         s3_status_in = STATUS_OK;
      end
   end

   logic [DATA_BITS-1:0] extracted;
   always_comb begin
      int k;
      k = 0;
      extracted = '0;
      for (int p = FIRST_DATA_POS; p < CODE_LEN; p++) begin
         if (!is_pow2(p) && k < DATA_BITS) begin
            extracted[k] = fixed[p];
            k++;
         end
      end
   end

   assign s3_code_in = (s2_op_ff == OP_ENCODE) ? encoded : '0;
   assign s3_data_in = (s2_op_ff == OP_DECODE) ? extracted : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ready3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (ready3) begin
         s3_code_ff   <= s3_code_in;
         s3_data_ff   <= s3_data_in;
         s3_status_ff <= s3_status_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = BUS_W'({s3_data_ff, s3_code_ff});
   assign rsp_tuser  = s3_status_ff;

   // an error status only comes from a decode, which carries no codeword
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_status_ff != STATUS_OK) |-> (s3_code_ff == '0))
      else $error("error status on an encode transaction");

   // a stalled stage 2 keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !ready3) |=> (s2_valid_ff && $stable(s2_word_ff)))
      else $error("stage 2 lost or changed a stalled transaction");

   // a stalled output register keeps its result
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !rsp_tready) |=> (s3_valid_ff && $stable(s3_data_ff)
         && $stable(s3_code_ff) && $stable(s3_status_ff)))
      else $error("output register changed under stall");

   // encode leaves no data field, decode no codeword field
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_code_ff == '0 || s3_data_ff == '0))
      else $error("both result fields nonzero");

endmodule

### tb/hamming_secded_codec_test.sv
`timescale 1ns / 1ps

module hamming_secded_codec_test;
   import hsc_pkg::*;

   localparam int DATA_BITS  = 32;
   localparam int CODE_BITS  = 39;
   localparam int TDATA_BITS = 72;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [CODE_BITS-1:0] codeword;
      logic [DATA_BITS-1:0] data;
      status_type           status;
   } codec_result;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_BITS-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_BITS-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   bit          gaps_enabled = 1'b1;
   int          mismatch_count = 0;
   int          stall_cycles = 0;
   codec_result pending_results[$];

   hamming_secded_codec #(
      .DATA_BITS(DATA_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // XOR of the positions of all set bits 1..CODE_BITS-1
   function automatic logic [5:0] position_xor(input logic [CODE_BITS-1:0] word);
      logic [5:0] s;
      s = '0;
      for (int p = 1; p < CODE_BITS; p++) begin
         if (word[p]) begin
            s ^= p[5:0];
         end
      end
      return s;
   endfunction

   function automatic codec_result predict_codec(input op_type op,
                                                 input logic [DATA_BITS-1:0] data_word,
                                                 input logic [CODE_BITS-1:0] cw);
      codec_result r;
      logic [CODE_BITS-1:0] word;
      logic [5:0] synd;
      int k;
      r.codeword = '0;
      r.data = '0;
      r.status = STATUS_OK;
      if (op == OP_ENCODE) begin
         word = '0;
         k = 0;
         for (int p = 3; p < CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
               word[p] = data_word[k];
               k++;
            end
         end
         synd = position_xor(word);
         for (int b = 0; b < 6; b++) begin
            word[1 << b] = synd[b];
         end
         word[0] = ^word;
         r.codeword = word;
      end else begin
         word = cw;
         synd = position_xor(cw);
         if (synd == 0) begin
            r.status = (^cw) ? STATUS_CORRECTED : STATUS_OK;
         end else if (!(^cw) || synd >= CODE_BITS) begin
            r.status = STATUS_DOUBLE;
         end else begin
            word[synd] = ~word[synd];
            r.status = STATUS_CORRECTED;
         end
         k = 0;
         for (int p = 3; p < CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
               r.data[k] = word[p];
               k++;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [CODE_BITS-1:0] encoded(input logic [DATA_BITS-1:0] d);
      codec_result r;
      r = predict_codec(OP_ENCODE, d, '0);
      return r.codeword;
   endfunction

   function automatic logic [CODE_BITS-1:0] random_word();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[CODE_BITS-1:0];
   endfunction

   task automatic send_request(input op_type op, input logic [DATA_BITS-1:0] data_word,
                               input logic [CODE_BITS-1:0] cw);
      @(negedge clock);
      while (gaps_enabled && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, cw, data_word};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic test_encode_extremes();
      send_request(OP_ENCODE, 32'h0000_0000, random_word());
      send_request(OP_ENCODE, 32'hFFFF_FFFF, random_word());
      send_request(OP_ENCODE, 32'h5555_5555, random_word());
      send_request(OP_ENCODE, 32'hAAAA_AAAA, '1);
      send_request(OP_ENCODE, 32'h0000_0001, random_word());
      send_request(OP_ENCODE, 32'h8000_0000, random_word());
   endtask

   task automatic test_decode_clean();
      send_request(OP_DECODE, $urandom, encoded(32'h0000_0000));
      send_request(OP_DECODE, '1, encoded(32'hFFFF_FFFF));
      send_request(OP_DECODE, $urandom, encoded($urandom));
   endtask

   // flips in the overall bit, a parity bit, the first and last data positions
   task automatic test_single_error();
      send_request(OP_DECODE, $urandom, encoded($urandom) ^ 39'd1);
      send_request(OP_DECODE, $urandom, encoded($urandom) ^ (39'd1 << 1));
      send_request(OP_DECODE, $urandom, encoded($urandom) ^ (39'd1 << 3));
      send_request(OP_DECODE, $urandom, encoded($urandom) ^ (39'd1 << 38));
   endtask

   task automatic test_double_error();
      send_request(OP_DECODE, $urandom, encoded($urandom) ^ ((39'd1 << 1) | (39'd1 << 2)));
      send_request(OP_DECODE, $urandom, encoded($urandom) ^ (39'd1 | (39'd1 << 5)));
      send_request(OP_DECODE, $urandom, encoded($urandom) ^ ((39'd1 << 3) | (39'd1 << 38)));
   endtask

   // odd error count whose syndrome lands beyond the last code position
   task automatic test_syndrome_past_end();
      send_request(OP_DECODE, $urandom,
                   encoded($urandom) ^ (39'd1 | (39'd1 << 7) | (39'd1 << 32)));
      send_request(OP_DECODE, $urandom,
                   encoded($urandom) ^ (39'd1 | (39'd1 << 31) | (39'd1 << 32)));
      send_request(OP_DECODE, $urandom, '1);
   endtask

   task automatic test_random_traffic(input int count);
      logic [CODE_BITS-1:0] cw;
      int kind;
      int flips;
      int pos;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            send_request(OP_ENCODE, $urandom, random_word());
         end else if (kind < 85) begin
            cw = encoded($urandom);
            flips = $urandom_range(3);
            for (int f = 0; f < flips; f++) begin
               pos = $urandom_range(CODE_BITS - 1);
               cw[pos] = ~cw[pos];
            end
            send_request(OP_DECODE, $urandom, cw);
         end else begin
            send_request(OP_DECODE, $urandom, random_word());
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= !gaps_enabled || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin : check_results
      codec_result want;
      logic [CODE_BITS-1:0] got_cw;
      logic [DATA_BITS-1:0] got_data;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_results.insert(pending_results.size(),
                                   predict_codec(op_type'(req_tuser),
                                                 req_tdata[DATA_BITS-1:0],
                                                 req_tdata[DATA_BITS +: CODE_BITS]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got_cw   = rsp_tdata[CODE_BITS-1:0];
            got_data = rsp_tdata[CODE_BITS +: DATA_BITS];
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected rsp: cw=%h data=%h status=%0d",
                           got_cw, got_data, rsp_tuser);
               end
            end else begin
               want = pending_results.pop_front();
               if (got_cw !== want.codeword || got_data !== want.data ||
                   rsp_tuser !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected cw=%h data=%h status=%0d",
                              want.codeword, want.data, want.status,
                              ", got cw=%h data=%h status=%0d",
                              got_cw, got_data, rsp_tuser);
                  end
               end
            end
         end
      end
   end

   // cycles without any transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction in %0d cycles", STALL_LIMIT);
            $display("hamming_secded_codec test failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_encode_extremes();
      test_decode_clean();
      test_single_error();
      test_double_error();
      test_syndrome_past_end();

      test_random_traffic(600);
      gaps_enabled = 1'b0;
      test_random_traffic(400);
      gaps_enabled = 1'b1;
      test_random_traffic(600);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("hamming_secded_codec test passed");
      end else begin
         $display("hamming_secded_codec test failed");
      end
      $finish;
   end

endmodule
